// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL that checks itself
// Clocked on clk_i, quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_PROP(label, !(expr), msg)

`endif

// ===== rtl/core/mwm_pkg.sv =====
// ----------------------------------------------------------------------------
// mwm_pkg
// Types and constants shared by the whitespace minifier modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mwm_pkg;

  // Body modes of the parser
  localparam logic [2:0] MODE_OUT   = 3'd0;
  localparam logic [2:0] MODE_READ  = 3'd1;
  localparam logic [2:0] MODE_LOOSE = 3'd2;
  localparam logic [2:0] MODE_VERB  = 3'd3;
  localparam logic [2:0] MODE_CLOSE = 3'd4;

  // Characters of interest
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_E     = 8'h65;

  // Queue between classifier and output stage
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QAW         = 2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/mwm_front.sv =====
// ----------------------------------------------------------------------------
// mwm_front
// Accepts input words, runs the tag/body mode machine and queues kept bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module mwm_front import mwm_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned TAG_LIMIT   = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_valid_i,
  input  wire logic [7:0] s_byte_i,
  input  wire logic       s_end_i,
  output logic            s_ready_o,
  input  wire fifo_stat_t q_stat_i,
  output logic            push_o,
  output out_item_t       push_item_o
);

  localparam int unsigned LW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(TAG_LIMIT + 1);

  logic [2:0]    mode_q, mode_d;
  logic [7:0]    head_q [4];
  logic [7:0]    head_d [4];
  logic [CW-1:0] count_q, count_d;
  logic [7:0]    prev_q, prev_d;
  logic [LW-1:0] level_q, level_d;
  logic [LW-1:0] rd_addr;
  logic          verb_mem [STACK_DEPTH];
  logic          rd_verb_q;
  logic          wr_en, wr_verb;
  logic          keep, accept, name_pre;
  logic [2:0]    parent_mode;

  assign s_ready_o = !q_stat_i.full;
  assign accept    = s_valid_i && s_ready_o;

  assign name_pre = (count_q >= CW'(3)) && (head_q[0] == CH_P) && (head_q[1] == CH_R) &&
                    (head_q[2] == CH_E) && ((count_q == CW'(3)) || (head_q[3] == 8'h00));

  // Level zero and one fall back to outside; deeper levels use the prefetched entry
  assign parent_mode = (level_q <= LW'(1)) ? MODE_OUT : (rd_verb_q ? MODE_VERB : MODE_LOOSE);

  always_comb begin
    mode_d  = mode_q;
    head_d  = head_q;
    count_d = count_q;
    prev_d  = prev_q;
    level_d = level_q;
    keep    = 1'b0;
    wr_en   = 1'b0;
    wr_verb = 1'b0;
    if (accept) begin
      if (s_end_i) begin
        mode_d  = MODE_OUT;
        head_d  = '{default: '0};
        count_d = '0;
        prev_d  = '0;
        level_d = '0;
      end else begin
        prev_d = s_byte_i;
        unique case (mode_q)
          MODE_OUT: begin
            if (s_byte_i == CH_LT) begin
              head_d  = '{default: '0};
              count_d = '0;
              mode_d  = MODE_READ;
              keep    = 1'b1;
            end
          end
          MODE_READ: begin
            keep = 1'b1;
            if (s_byte_i == CH_GT) begin
              if (level_q != LW'(STACK_DEPTH - 1)) begin
                level_d = level_q + LW'(1);
              end
              mode_d  = name_pre ? MODE_VERB : MODE_LOOSE;
              wr_en   = 1'b1;
              wr_verb = name_pre;
            end else begin
              if (count_q < CW'(4)) begin
                head_d[count_q[1:0]] = s_byte_i;
              end
              if (count_q < CW'(TAG_LIMIT)) begin
                count_d = count_q + CW'(1);
              end
            end
          end
          MODE_LOOSE: begin
            keep = 1'b1;
            if (s_byte_i == CH_SLASH) begin
              keep = (prev_q == CH_LT);
              if (prev_q == CH_LT) begin
                mode_d = MODE_CLOSE;
              end
            end else if (s_byte_i == CH_SPACE) begin
              keep = (prev_q != CH_SPACE);
            end else if ((s_byte_i == CH_TAB) || (s_byte_i == CH_NL)) begin
              keep = 1'b0;
            end
          end
          MODE_VERB: begin
            keep = 1'b1;
            if ((s_byte_i == CH_SLASH) && (prev_q == CH_LT)) begin
              mode_d = MODE_CLOSE;
            end
          end
          MODE_CLOSE: begin
            keep = 1'b1;
            if (s_byte_i == CH_GT) begin
              if (level_q != '0) begin
                level_d = level_q - LW'(1);
              end
              mode_d = parent_mode;
            end
          end
          default: begin
            mode_d = MODE_OUT;
            keep   = 1'b0;
          end
        endcase
      end
    end
  end

  // Prefetch the mode of the enclosing level for the next cycle
  assign rd_addr = (level_d == '0) ? '0 : level_d - LW'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      verb_mem[level_d] <= wr_verb;
    end
    rd_verb_q <= verb_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_OUT;
      head_q  <= '{default: '0};
      count_q <= '0;
      prev_q  <= '0;
      level_q <= '0;
    end else begin
      mode_q  <= mode_d;
      head_q  <= head_d;
      count_q <= count_d;
      prev_q  <= prev_d;
      level_q <= level_d;
    end
  end

  assign push_o               = accept && (s_end_i || keep);
  assign push_item_o.out_byte = s_end_i ? CH_NL : s_byte_i;
  assign push_item_o.last     = s_end_i;

endmodule

`default_nettype wire

// ===== rtl/core/mwm_fifo.sv =====
// ----------------------------------------------------------------------------
// mwm_fifo
// Short queue of kept bytes between classifier and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mwm_fifo import mwm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire out_item_t push_item_i,
  input  wire logic      pop_i,
  output out_item_t      pop_item_o,
  output fifo_stat_t     stat_o
);

  out_item_t      mem_q [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAW:0]   cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QAW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QAW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QAW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QAW+1)'(1);
      end
    end
  end

  assign pop_item_o   = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == (QAW+1)'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

// ===== rtl/core/mwm_back.sv =====
// ----------------------------------------------------------------------------
// mwm_back
// Output register: drains the queue onto the master stream.
// ----------------------------------------------------------------------------
`default_nettype none

module mwm_back import mwm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire fifo_stat_t q_stat_i,
  input  wire out_item_t  q_item_i,
  output logic            pop_o,
  output logic            m_valid_o,
  input  wire logic       m_ready_i,
  output logic [7:0]      m_data_o,
  output logic            m_last_o
);

  logic      valid_q;
  out_item_t item_q;

  // Refill whenever the register is free or being taken
  assign pop_o = !q_stat_i.empty && (!valid_q || m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (m_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= q_item_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = item_q.out_byte;
  assign m_last_o  = item_q.last;

endmodule

`default_nettype wire

// ===== rtl/core/markup_whitespace_minifier.sv =====
// ----------------------------------------------------------------------------
// markup_whitespace_minifier
// Byte-stream filter that strips whitespace from markup text.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one markup byte per word on s_axis_tdata_i. A word with
//   s_axis_tlast_i high ends the stream: its data is ignored, a newline word
//   with m_axis_tlast_o high is emitted and the parser returns to reset state.
//   Master stream: one kept byte per word; zero or one output word per input.
// Path: a kept byte is written into the queue at the edge that accepts it
//   and is moved into the output register once that register is free or
//   being taken, which makes it visible on the master side.
// Throughput: one word per cycle on both sides unless stalled. The classifier
//   decides each byte combinationally; the enclosing level's body mode is
//   prefetched from the level stack every cycle, so a closing '>' never waits.
// Stall: when the receiver holds m_axis_tready_i low, the output register
//   holds its word and the four-word queue fills; s_axis_tready_o drops only
//   once the queue is full.
// Reset: rst_ni clears the mode machine, tag name, level counter and queue.
//   The level stack memory is not cleared; entries are always written
//   before their value is used.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module markup_whitespace_minifier import mwm_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned TAG_LIMIT   = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic       s_axis_tlast_i,   // end_of_input
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] out_byte
  output logic            m_axis_tlast_o    // last
);

  fifo_stat_t fifo_stat;
  out_item_t  push_item, pop_item;
  logic       fifo_push, fifo_pop;
  logic       last_out;

  // Classify each word and keep or drop it
  mwm_front #(
    .STACK_DEPTH (STACK_DEPTH),
    .TAG_LIMIT   (TAG_LIMIT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_byte_i    (s_axis_tdata_i),
    .s_end_i     (s_axis_tlast_i),
    .s_ready_o   (s_axis_tready_o),
    .q_stat_i    (fifo_stat),
    .push_o      (fifo_push),
    .push_item_o (push_item)
  );

  // Buffer kept words so each side can stall on its own
  mwm_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_item_i (push_item),
    .pop_i       (fifo_pop),
    .pop_item_o  (pop_item),
    .stat_o      (fifo_stat)
  );

  // Drive the master stream from a register
  mwm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_stat_i  (fifo_stat),
    .q_item_i  (pop_item),
    .pop_o     (fifo_pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o),
    .m_last_o  (m_axis_tlast_o)
  );

  assign last_out = m_axis_tvalid_o && m_axis_tlast_o;

  // Front never writes a full queue
  `ASSERT_NEVER(a_no_overflow, fifo_push && fifo_stat.full, "queue overflow")
  // Back never reads an empty queue
  `ASSERT_NEVER(a_no_underflow, fifo_pop && fifo_stat.empty, "queue underflow")
  // The closing word is always a newline
  `ASSERT_PROP(a_last_newline, last_out |-> (m_axis_tdata_o == CH_NL), "last word not newline")

endmodule

`default_nettype wire
